FILE: sv/rast_pkg.sv
// Package with shared constants and helper functions for the segment tree unit.
package rast_pkg;
    localparam int LEAF_COUNT = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int NODE_COUNT = 2 * LEAF_COUNT;
    localparam int LEAF_BITS = $clog2(LEAF_COUNT);
    localparam int ADDR_BITS = $clog2(NODE_COUNT);
    localparam int POS_WIDTH = 10;
    localparam int END_WIDTH = 11;
    localparam int DATA_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH = 2;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_FILL   = 2'd3;

    localparam logic [1:0] MODE_SUM = 2'd0;
    localparam logic [1:0] MODE_MIN = 2'd1;
    localparam logic [1:0] MODE_MAX = 2'd2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COMBINE = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPDATE  = 1'd1;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [ADDR_BITS-1:0] addr_t;

    typedef struct packed {
        logic       we;
        addr_t      addr;
        value_t     wdata;
    } mem_req_t;

    function automatic value_t combine(input logic [1:0] mode, input value_t a,
                                       input value_t b);
        value_t res;
        case (mode)
            MODE_MIN: res = ($signed(b) < $signed(a)) ? b : a;
            MODE_MAX: res = ($signed(a) < $signed(b)) ? b : a;
            default:  res = a + b;
        endcase
        return res;
    endfunction

    function automatic value_t identity(input logic [1:0] mode);
        value_t res;
        case (mode)
            MODE_MIN: res = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            MODE_MAX: res = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            default:  res = '0;
        endcase
        return res;
    endfunction
endpackage

FILE: sv/rast_if.sv
// Valid/ready stream interfaces for requests and results.
interface rast_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic [rast_pkg::POS_WIDTH-1:0] position;
    logic [rast_pkg::END_WIDTH-1:0] end_position;
    logic signed [rast_pkg::DATA_WIDTH-1:0] value;
    modport source (output valid, op, position, end_position, value, input ready);
    modport sink (input valid, op, position, end_position, value, output ready);
endinterface

interface rast_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [rast_pkg::DATA_WIDTH-1:0] result;
    modport source (output valid, result, input ready);
    modport sink (input valid, result, output ready);
endinterface

FILE: sv/rast_ram.sv
// Generic single-port RAM with registered read.
module rast_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: sv/rast_ctrl.sv
// Sequencer that walks the tree for updates, queries, reads, fills and clearing.
module rast_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           combine_mode,
    input  logic                 update_mode,
    rast_req_if.sink             req,
    rast_rsp_if.source           rsp,
    output rast_pkg::mem_req_t   mem_req,
    input  rast_pkg::value_t     mem_rdata
);
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ULEAF  = 4'd2;  // leaf read issued
    localparam logic [3:0] S_UWRITE = 4'd3;  // write node, then read sibling
    localparam logic [3:0] S_USIB   = 4'd4;  // sibling read issued
    localparam logic [3:0] S_QSTEP  = 4'd5;
    localparam logic [3:0] S_QWAIT  = 4'd6;
    localparam logic [3:0] S_RWAIT  = 4'd7;
    localparam logic [3:0] S_FLEAF  = 4'd8;
    localparam logic [3:0] S_FRDA   = 4'd9;
    localparam logic [3:0] S_FRDB   = 4'd10;
    localparam logic [3:0] S_FWR    = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam int AB = rast_pkg::ADDR_BITS;

    logic [3:0]              state_reg, state_next;
    logic [AB:0]             node_reg, node_next;     // update node / left / fill index, one bit spare
    logic [AB:0]             rgt_reg, rgt_next;       // query right bound, one bit spare
    rast_pkg::value_t        accl_reg, accl_next;
    rast_pkg::value_t        accr_reg, accr_next;
    rast_pkg::value_t        val_reg, val_next;
    rast_pkg::value_t        hold_reg, hold_next;
    logic                    side_reg, side_next;     // read: position in range; S_FRDB: update sibling (1) or fill (0)
    logic                    lpend_reg, lpend_next;
    logic signed [rast_pkg::DATA_WIDTH-1:0] out_reg, out_next;

    rast_pkg::value_t        ext_val;
    rast_pkg::value_t        new_node;

    assign ext_val = rast_pkg::value_t'(req.value);
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.result = out_reg;

    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        rgt_next   = rgt_reg;
        accl_next  = accl_reg;
        accr_next  = accr_reg;
        val_next   = val_reg;
        hold_next  = hold_reg;
        side_next  = side_reg;
        lpend_next = lpend_reg;
        out_next   = out_reg;
        mem_req    = '0;
        new_node   = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_req.we   = 1'b1;
                mem_req.addr = rast_pkg::addr_t'(node_reg);
                node_next    = node_reg + 1'b1;
                if (node_reg == (AB+1)'(rast_pkg::NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    val_next = ext_val;
                    case (req.op)
                        rast_pkg::OP_UPDATE:
                        begin
                            if ({1'b0, req.position} < (rast_pkg::POS_WIDTH+1)'(
                                rast_pkg::LEAF_COUNT))
                            begin
                                node_next    = (AB+1)'(req.position)
                                             + (AB+1)'(rast_pkg::LEAF_COUNT);
                                mem_req.addr = rast_pkg::addr_t'(req.position)
                                             + rast_pkg::addr_t'(rast_pkg::LEAF_COUNT);
                                state_next   = S_ULEAF;
                            end
                        end
                        rast_pkg::OP_QUERY:
                        begin
                            accl_next = rast_pkg::identity(combine_mode);
                            accr_next = rast_pkg::identity(combine_mode);
                            node_next = (AB+1)'(req.position)
                                      + (AB+1)'(rast_pkg::LEAF_COUNT);
                            if (req.end_position > (rast_pkg::END_WIDTH)'(rast_pkg::LEAF_COUNT))
                            begin
                                rgt_next = (AB+1)'(2 * rast_pkg::LEAF_COUNT);
                            end
                            else
                            begin
                                rgt_next = (AB+1)'(req.end_position)
                                         + (AB+1)'(rast_pkg::LEAF_COUNT);
                            end
                            lpend_next = 1'b0;
                            state_next = S_QSTEP;
                        end
                        rast_pkg::OP_READ:
                        begin
                            mem_req.addr = rast_pkg::addr_t'(req.position)
                                         + rast_pkg::addr_t'(rast_pkg::LEAF_COUNT);
                            side_next    = ({1'b0, req.position} < (rast_pkg::POS_WIDTH+1)'(
                                           rast_pkg::LEAF_COUNT));
                            state_next   = S_RWAIT;
                        end
                        default:
                        begin
                            node_next  = (AB+1)'(rast_pkg::LEAF_COUNT);
                            state_next = S_FLEAF;
                        end
                    endcase
                end
            end
            S_ULEAF:
            begin
                // Leaf data is back; compute the new leaf.
                hold_next  = update_mode ? rast_pkg::combine(combine_mode, mem_rdata, val_reg)
                                         : val_reg;
                state_next = S_UWRITE;
            end
            S_UWRITE:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = rast_pkg::addr_t'(node_reg);
                mem_req.wdata = hold_reg;
                if (node_reg == (AB+1)'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_USIB;
                end
            end
            S_USIB:
            begin
                // Issue the sibling read this cycle; combine next cycle.
                mem_req.addr = rast_pkg::addr_t'(node_reg) ^ rast_pkg::addr_t'(1);
                state_next   = S_FRDB;
                side_next    = 1'b1;
            end
            S_QSTEP:
            begin
                if (lpend_reg)
                begin
                    accl_next = rast_pkg::combine(combine_mode, accl_reg, mem_rdata);
                    lpend_next = 1'b0;
                end
                if (node_reg >= rgt_reg)
                begin
                    if (lpend_reg)
                    begin
                        out_next = $signed(rast_pkg::combine(combine_mode,
                            rast_pkg::combine(combine_mode, accl_reg, mem_rdata), accr_reg));
                    end
                    else
                    begin
                        out_next = $signed(rast_pkg::combine(combine_mode, accl_reg, accr_reg));
                    end
                    state_next = S_OUT;
                end
                else if (node_reg[0])
                begin
                    mem_req.addr = rast_pkg::addr_t'(node_reg);
                    lpend_next   = 1'b1;
                    node_next    = node_reg + 1'b1;
                    state_next   = S_QWAIT;
                end
                else if (rgt_reg[0])
                begin
                    mem_req.addr = rast_pkg::addr_t'(rgt_reg - 1'b1);
                    rgt_next     = rgt_reg - 1'b1;
                    state_next   = S_QWAIT;
                end
                else
                begin
                    node_next = node_reg >> 1;
                    rgt_next  = rgt_reg >> 1;
                end
            end
            S_QWAIT:
            begin
                if (lpend_reg)
                begin
                    accl_next  = rast_pkg::combine(combine_mode, accl_reg, mem_rdata);
                    lpend_next = 1'b0;
                    if (rgt_reg[0] && (node_reg < rgt_reg))
                    begin
                        mem_req.addr = rast_pkg::addr_t'(rgt_reg - 1'b1);
                        rgt_next     = rgt_reg - 1'b1;
                    end
                    else
                    begin
                        node_next  = node_reg >> 1;
                        rgt_next   = rgt_reg >> 1;
                        state_next = S_QSTEP;
                    end
                end
                else
                begin
                    accr_next  = rast_pkg::combine(combine_mode, mem_rdata, accr_reg);
                    node_next  = node_reg >> 1;
                    rgt_next   = rgt_reg >> 1;
                    state_next = S_QSTEP;
                end
            end
            S_RWAIT:
            begin
                out_next   = side_reg ? $signed(mem_rdata) : '0;
                state_next = S_OUT;
            end
            S_FLEAF:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = rast_pkg::addr_t'(node_reg);
                mem_req.wdata = val_reg;
                node_next     = node_reg + 1'b1;
                if (node_reg == (AB+1)'(rast_pkg::NODE_COUNT - 1))
                begin
                    node_next  = (AB+1)'(rast_pkg::LEAF_COUNT - 1);
                    state_next = S_FRDA;
                end
            end
            S_FRDA:
            begin
                // Read left child of node_reg.
                mem_req.addr = rast_pkg::addr_t'(node_reg << 1);
                side_next    = 1'b0;
                state_next   = S_FRDB;
            end
            S_FRDB:
            begin
                if (side_reg)
                begin
                    // Update walk: sibling data is back, combine in order.
                    if (node_reg[0])
                    begin
                        hold_next = rast_pkg::combine(combine_mode, mem_rdata, hold_reg);
                    end
                    else
                    begin
                        hold_next = rast_pkg::combine(combine_mode, hold_reg, mem_rdata);
                    end
                    node_next  = node_reg >> 1;
                    state_next = S_UWRITE;
                end
                else
                begin
                    hold_next    = mem_rdata;
                    mem_req.addr = rast_pkg::addr_t'((node_reg << 1) | (AB+1)'(1));
                    state_next   = S_FWR;
                end
            end
            S_FWR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = rast_pkg::addr_t'(node_reg);
                mem_req.wdata = rast_pkg::combine(combine_mode, hold_reg, mem_rdata);
                node_next     = node_reg - 1'b1;
                if (node_reg == (AB+1)'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FRDA;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        new_node = hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            node_reg  <= '0;
            lpend_reg <= 1'b0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            lpend_reg <= lpend_next;
            side_reg  <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rgt_reg  <= rgt_next;
        accl_reg <= accl_next;
        accr_reg <= accr_next;
        val_reg  <= val_next;
        hold_reg <= new_node;
        out_reg  <= out_next;
    end
endmodule

FILE: sv/range_aggregate_segment_tree_unit.sv
// Top level: configuration registers, walk sequencer and node memory.
// Clearing after reset writes zero to all 2048 nodes, one a cycle.
// Update: each tree level takes a write, a sibling read and a combine, as the node memory has one port.
// Query: climbs the tree level by level, reading odd boundary nodes, then the result; read: one leaf read.
// Fill: 1024 leaf writes, then each inner node from 1023 down to 1 gets a left read, right read and write.
// One transaction is in work at a time; reset clears the state and configuration registers and starts the clear.
module range_aggregate_segment_tree_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [rast_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [rast_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    rast_req_if.sink                               req,
    rast_rsp_if.source                             rsp
);
    logic [1:0]          combine_mode_reg;
    logic                update_mode_reg;
    rast_pkg::mem_req_t  mem_req;
    rast_pkg::value_t    mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            combine_mode_reg <= rast_pkg::MODE_SUM;
            update_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rast_pkg::REG_COMBINE: combine_mode_reg <= cfg_data;
                rast_pkg::REG_UPDATE:  update_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    rast_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .combine_mode (combine_mode_reg),
        .update_mode  (update_mode_reg),
        .req          (req),
        .rsp          (rsp),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata)
    );

    rast_ram #(
        .WIDTH (rast_pkg::VALUE_WIDTH),
        .DEPTH (rast_pkg::NODE_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );
endmodule

FILE: sv/rast_checker.sv
// Port-level checker for the segment tree unit, bound to the top level.
module rast_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic [31:0] rsp_result
);
    // Only one transaction is in work, so a waiting result blocks new requests.
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted while a result waits");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
        else $error("result dropped or changed while stalled");

    // A result never appears in the cycle right after acceptance.
    a_result_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !rsp_valid)
        else $error("result too early");

    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> req_ready)
        else $error("unit not ready after delivering a result");
endmodule

bind range_aggregate_segment_tree_unit rast_checker u_rast_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_result (rsp.result)
);

FILE: test/testbench.sv
// Testbench for the segment tree unit: random and directed traffic checked against a predictor.
`timescale 1ns / 1ps

class seg_tree_scoreboard;
    logic [31:0] nodes [0:2047];
    logic [1:0]  combine_mode;
    logic        update_mode;
    logic [31:0] expected_results [$];
    int          errors;

    function new();
        foreach (nodes[i])
        begin
            nodes[i] = '0;
        end
        combine_mode = rast_pkg::MODE_SUM;
        update_mode = 1'b0;
        errors = 0;
    endfunction

    function logic [31:0] merge(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] res;
        if (combine_mode == rast_pkg::MODE_MIN)
        begin
            res = ($signed(b) < $signed(a)) ? b : a;
        end
        else if (combine_mode == rast_pkg::MODE_MAX)
        begin
            res = ($signed(a) < $signed(b)) ? b : a;
        end
        else
        begin
            res = a + b;
        end
        return res;
    endfunction

    function logic [31:0] neutral();
        logic [31:0] res;
        if (combine_mode == rast_pkg::MODE_MIN)
        begin
            res = 32'h7fff_ffff;
        end
        else if (combine_mode == rast_pkg::MODE_MAX)
        begin
            res = 32'h8000_0000;
        end
        else
        begin
            res = '0;
        end
        return res;
    endfunction

    function void set_register(input logic idx, input logic [1:0] data);
        if (idx == rast_pkg::REG_COMBINE)
        begin
            combine_mode = data;
        end
        else
        begin
            update_mode = data[0];
        end
    endfunction

    function void note_request(input logic [1:0] op, input logic [9:0] pos,
                               input logic [10:0] endp, input logic [31:0] val);
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        logic [31:0] acc_left;
        logic [31:0] acc_right;
        case (op)
            rast_pkg::OP_UPDATE:
            begin
                k = pos + 1024;
                nodes[k] = update_mode ? merge(nodes[k], val) : val;
                while (k > 1)
                begin
                    k = k >> 1;
                    nodes[k] = merge(nodes[2 * k], nodes[2 * k + 1]);
                end
            end
            rast_pkg::OP_QUERY:
            begin
                acc_left = neutral();
                acc_right = neutral();
                lo = pos + 1024;
                hi = ((endp > 1024) ? 1024 : endp) + 1024;
                while (lo < hi)
                begin
                    if (lo[0])
                    begin
                        acc_left = merge(acc_left, nodes[lo]);
                        lo++;
                    end
                    if (hi[0])
                    begin
                        hi--;
                        acc_right = merge(nodes[hi], acc_right);
                    end
                    lo = lo >> 1;
                    hi = hi >> 1;
                end
                expected_results.push_back(merge(acc_left, acc_right));
            end
            rast_pkg::OP_READ:
            begin
                expected_results.push_back(nodes[pos + 1024]);
            end
            default:
            begin
                for (k = 1024; k < 2048; k++)
                begin
                    nodes[k] = val;
                end
                for (k = 1023; k >= 1; k--)
                begin
                    nodes[k] = merge(nodes[2 * k], nodes[2 * k + 1]);
                end
            end
        endcase
    endfunction

    task report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task check_result(input logic [31:0] got);
        logic [31:0] want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result %h", got));
        end
        else
        begin
            want = expected_results.pop_front();
            if (got !== want)
            begin
                report_mismatch($sformatf("result %h, expected %h", got, want));
            end
        end
    endtask
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int IDLE_PAUSE = 4300;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [1:0] cfg_data;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         quiet_cycles;

    seg_tree_scoreboard sb;

    rast_req_if req ();
    rast_rsp_if rsp ();

    range_aggregate_segment_tree_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    always #1 clk = ~clk;

    // Results are checked with pre-edge values; the stall pattern is redrawn every cycle.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            sb.check_result(rsp.result);
        end
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task send_item(input logic [1:0] op, input logic [9:0] pos,
                   input logic [10:0] endp, input logic [31:0] val);
        int gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.position <= pos;
        req.end_position <= endp;
        req.value <= val;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        sb.note_request(op, pos, endp, val);
    endtask

    // Waits for every expected result, then lets any update or fill finish.
    task drain_block();
        req.valid <= 1'b0;
        while (sb.expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task write_register(input logic idx, input logic [1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, data);
        @(posedge clk);
    endtask

    function logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(9))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'hffff_ffff;
            3: v = 32'd0;
            4: v = $urandom_range(0, 15);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task random_item();
        logic [9:0]  pos;
        logic [10:0] endp;
        int unsigned pick;
        pick = $urandom_range(999);
        pos = 10'($urandom_range(0, 1023));
        if ($urandom_range(9) == 0)
        begin
            endp = 11'($urandom_range(0, 2047));
        end
        else if ($urandom_range(3) == 0)
        begin
            endp = 11'($urandom_range(0, 1024));
        end
        else
        begin
            endp = 11'(pos) + 11'($urandom_range(0, 40));
        end
        if (pick < 5)
        begin
            send_item(rast_pkg::OP_FILL, pos, endp, pick_value());
        end
        else if (pick < 420)
        begin
            send_item(rast_pkg::OP_UPDATE, pos, endp, pick_value());
        end
        else if (pick < 760)
        begin
            send_item(rast_pkg::OP_QUERY, pos, endp, pick_value());
        end
        else
        begin
            send_item(rast_pkg::OP_READ, pos, endp, pick_value());
        end
    endtask

    logic [1:0] combine_plan [0:7];
    logic       update_plan [0:7];

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.op = rast_pkg::OP_UPDATE;
        req.position = '0;
        req.end_position = '0;
        req.value = '0;
        rsp.ready = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 10;
        recv_idle_pct = 84;
        sb = new();
        combine_plan = '{rast_pkg::MODE_SUM, rast_pkg::MODE_MIN, rast_pkg::MODE_MAX, 2'd3,
                         rast_pkg::MODE_SUM, rast_pkg::MODE_MAX, rast_pkg::MODE_MIN,
                         rast_pkg::MODE_MAX};
        update_plan = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_register(rast_pkg::REG_COMBINE, rast_pkg::MODE_SUM);
        write_register(rast_pkg::REG_UPDATE, 1'b0);

        // Directed part: cleared store, extremes, clamping and empty ranges.
        send_item(rast_pkg::OP_READ, 10'd0, 11'd0, 32'd0);
        send_item(rast_pkg::OP_QUERY, 10'd0, 11'd1024, 32'd0);
        send_item(rast_pkg::OP_UPDATE, 10'd0, 11'd0, 32'h7fff_ffff);
        send_item(rast_pkg::OP_UPDATE, 10'd1023, 11'd2047, 32'h8000_0000);
        send_item(rast_pkg::OP_UPDATE, 10'd512, 11'd0, 32'hffff_ffff);
        send_item(rast_pkg::OP_READ, 10'd1023, 11'd0, 32'd0);
        send_item(rast_pkg::OP_QUERY, 10'd0, 11'd2047, 32'd0);
        send_item(rast_pkg::OP_QUERY, 10'd1023, 11'd1024, 32'd0);
        send_item(rast_pkg::OP_QUERY, 10'd5, 11'd5, 32'd0);
        send_item(rast_pkg::OP_QUERY, 10'd1023, 11'd3, 32'd0);
        send_item(rast_pkg::OP_QUERY, 10'd1, 11'd1023, 32'd0);
        send_item(rast_pkg::OP_FILL, 10'd0, 11'd0, 32'hffff_fffb);
        send_item(rast_pkg::OP_READ, 10'd700, 11'd0, 32'd0);
        send_item(rast_pkg::OP_QUERY, 10'd0, 11'd1024, 32'd0);
        send_item(rast_pkg::OP_QUERY, 10'd100, 11'd1500, 32'd0);

        for (int phase = 0; phase < 8; phase++)
        begin
            drain_block();
            send_idle_pct = (phase < 3) ? 10 : ((phase < 6) ? 84 : 0);
            recv_idle_pct = (phase < 3) ? 84 : ((phase < 6) ? 10 : 0);
            write_register(rast_pkg::REG_COMBINE, combine_plan[phase]);
            write_register(rast_pkg::REG_UPDATE, update_plan[phase]);
            // An empty query probes the identity and a full query the whole tree right after the mode change.
            send_item(rast_pkg::OP_QUERY, 10'd9, 11'd9, 32'd0);
            send_item(rast_pkg::OP_QUERY, 10'd0, 11'd1024, 32'd0);
            for (int n = 0; n < 200; n++)
            begin
                random_item();
            end
        end

        req.valid <= 1'b0;
        while (sb.expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_PAUSE) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
